// ----- sv/drt_pkg.sv -----
`timescale 1ns / 1ps

package drt_pkg;

	// Operation codes carried in s_tuser.
	localparam logic [2:0] OP_MARK     = 3'd0;
	localparam logic [2:0] OP_MARK_ALL = 3'd1;
	localparam logic [2:0] OP_CLEAR    = 3'd2;
	localparam logic [2:0] OP_QUERY    = 3'd3;
	localparam logic [2:0] OP_END      = 3'd4;

	// Frame classification codes.
	localparam logic [1:0] KIND_FULL    = 2'd0;
	localparam logic [1:0] KIND_PARTIAL = 2'd1;
	localparam logic [1:0] KIND_SKIPPED = 2'd2;
	localparam logic [1:0] KIND_NONE    = 2'd3;

	// Register map.
	localparam logic [2:0] ADDR_TRACK_EN = 3'd0;

	localparam int CNT_OUT_W = 6;

	// One rectangle; x sits in the lowest bits.
	typedef struct packed {
		logic signed [15:0] h;
		logic signed [15:0] w;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} rect_t;

	// One result beat; hit sits in the lowest bit.
	typedef struct packed {
		logic [5:0]           pad;
		logic [31:0]          skipped_total;
		logic [31:0]          partial_total;
		logic [31:0]          full_total;
		logic [31:0]          frame_total;
		logic [1:0]           frame_kind;
		logic [CNT_OUT_W-1:0] region_count;
		logic                 full_redraw;
		logic                 hit;
	} result_t;

endpackage

// ----- sv/drt_ram.sv -----
`timescale 1ns / 1ps

module drt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/drt_overlap.sv -----
`timescale 1ns / 1ps

// Strict half-open overlap test of one query rectangle against one stored entry.
// Edges are formed at 17 bits signed so the sums cannot overflow.
module drt_overlap (
	input  drt_pkg::rect_t qry,
	input  drt_pkg::rect_t ent,
	output logic           hit
);

	logic signed [16:0] qx, qy, ex, ey;
	logic signed [16:0] qx_end, qy_end, ex_end, ey_end;

	always_comb begin
		qx     = {qry.x[15], qry.x};
		qy     = {qry.y[15], qry.y};
		ex     = {ent.x[15], ent.x};
		ey     = {ent.y[15], ent.y};
		qx_end = qx + {qry.w[15], qry.w};
		qy_end = qy + {qry.h[15], qry.h};
		ex_end = ex + {ent.w[15], ent.w};
		ey_end = ey + {ent.h[15], ent.h};
		hit    = (qx < ex_end) && (qx_end > ex) && (qy < ey_end) && (qy_end > ey);
	end

endmodule

// ----- sv/dirty_rectangle_tracker.sv -----
// Mark, mark-all, clear, end-frame, unused codes and queries that need no search: result
// registered when the item is accepted. A query that must search the table reads one entry
// per cycle through the single compare unit, comparing each entry after its registered read;
// it stops early on the first overlapping entry. One item is in work at a time.
// Asynchronous active-low reset clears the count and frame counters, sets full redraw and
// tracking on; the rectangle table is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module dirty_rectangle_tracker #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // rect_x, rect_y, rect_width, rect_height
	input  logic [2:0]   s_tuser,   // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata    // hit, full_redraw, region_count, frame_kind,
	                                // frame_total, full_total, partial_total, skipped_total
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                 state_q;
	logic                 trk_en_q;
	logic                 red_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        idx_q;
	logic                 rd_vld_q;
	logic [31:0]          frames_q, full_q, part_q, skip_q;
	drt_pkg::rect_t       qry_q;
	logic                 out_vld_q;
	drt_pkg::result_t     out_q;

	logic                 in_acc;
	logic [2:0]           op;
	drt_pkg::rect_t       in_rect;
	logic                 cfg_wr;

	logic                 red_n;
	logic [CW-1:0]        cnt_n;
	logic [31:0]          frames_n, full_n, part_n, skip_n;
	logic [1:0]           kind_n;
	logic                 hit_n;
	logic                 start_scan;
	logic                 wr_en;

	logic                 issue;
	logic [63:0]          rd_data;
	logic                 ovl;
	logic                 scan_hit;
	logic                 scan_done;
	logic                 load;
	drt_pkg::result_t     res_d;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready && (paddr == drt_pkg::ADDR_TRACK_EN);
	assign prdata   = (paddr == drt_pkg::ADDR_TRACK_EN) ? {31'd0, trk_en_q} : 32'd0;

	assign s_tready = (state_q == ST_IDLE) && (!out_vld_q || m_tready);
	assign in_acc   = s_tvalid && s_tready;
	assign op       = s_tuser;
	assign in_rect  = drt_pkg::rect_t'(s_tdata);

	// Next state for items that finish in the accept cycle.
	always_comb begin
		red_n      = red_q;
		cnt_n      = cnt_q;
		frames_n   = frames_q;
		full_n     = full_q;
		part_n     = part_q;
		skip_n     = skip_q;
		kind_n     = drt_pkg::KIND_NONE;
		hit_n      = 1'b0;
		start_scan = 1'b0;
		wr_en      = 1'b0;
		case (op)
			drt_pkg::OP_MARK: begin
				if (!trk_en_q || cnt_q >= CW'(TABLE_DEPTH)) begin
					red_n = 1'b1;
				end else begin
					wr_en = in_acc;
					cnt_n = cnt_q + CW'(1);
				end
			end
			drt_pkg::OP_MARK_ALL: begin
				red_n = 1'b1;
				cnt_n = '0;
			end
			drt_pkg::OP_CLEAR: begin
				red_n = 1'b0;
				cnt_n = '0;
			end
			drt_pkg::OP_QUERY: begin
				if (red_q || !trk_en_q) begin
					hit_n = 1'b1;
				end else if (cnt_q != '0) begin
					start_scan = 1'b1;
				end
			end
			drt_pkg::OP_END: begin
				frames_n = frames_q + 32'd1;
				if (red_q) begin
					full_n = full_q + 32'd1;
					kind_n = drt_pkg::KIND_FULL;
				end else if (cnt_q != '0) begin
					part_n = part_q + 32'd1;
					kind_n = drt_pkg::KIND_PARTIAL;
				end else begin
					skip_n = skip_q + 32'd1;
					kind_n = drt_pkg::KIND_SKIPPED;
				end
				red_n = 1'b0;
				cnt_n = '0;
			end
			default: begin
			end
		endcase
	end

	drt_ram #(
		.WIDTH (64),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cnt_q[AW-1:0]),
		.wdata (s_tdata),
		.re    (issue),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	drt_overlap u_overlap (
		.qry (qry_q),
		.ent (drt_pkg::rect_t'(rd_data)),
		.hit (ovl)
	);

	// The scan reads one entry per cycle; the compare sees it in the cycle after the read.
	assign issue     = (state_q == ST_SCAN) && (idx_q < cnt_q);
	assign scan_hit  = rd_vld_q && ovl;
	assign scan_done = (state_q == ST_SCAN) && (scan_hit || (!issue && !rd_vld_q));
	assign load      = (in_acc && !start_scan) || scan_done;

	always_comb begin
		res_d     = '0;
		res_d.pad = '0;
		if (scan_done) begin
			res_d.hit           = scan_hit;
			res_d.full_redraw   = red_q;
			res_d.region_count  = drt_pkg::CNT_OUT_W'(cnt_q);
			res_d.frame_kind    = drt_pkg::KIND_NONE;
			res_d.frame_total   = frames_q;
			res_d.full_total    = full_q;
			res_d.partial_total = part_q;
			res_d.skipped_total = skip_q;
		end else begin
			res_d.hit           = hit_n;
			res_d.full_redraw   = red_n;
			res_d.region_count  = drt_pkg::CNT_OUT_W'(cnt_n);
			res_d.frame_kind    = kind_n;
			res_d.frame_total   = frames_n;
			res_d.full_total    = full_n;
			res_d.partial_total = part_n;
			res_d.skipped_total = skip_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			trk_en_q  <= 1'b1;
			red_q     <= 1'b1;
			cnt_q     <= '0;
			idx_q     <= '0;
			rd_vld_q  <= 1'b0;
			frames_q  <= '0;
			full_q    <= '0;
			part_q    <= '0;
			skip_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				trk_en_q <= pwdata[0];
			end
			if (in_acc) begin
				red_q    <= red_n;
				cnt_q    <= cnt_n;
				frames_q <= frames_n;
				full_q   <= full_n;
				part_q   <= part_n;
				skip_q   <= skip_n;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && start_scan) begin
						state_q  <= ST_SCAN;
						idx_q    <= '0;
						rd_vld_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q  <= ST_IDLE;
						rd_vld_q <= 1'b0;
					end else begin
						rd_vld_q <= issue;
						if (issue) begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			qry_q <= in_rect;
		end
		if (load) begin
			out_q <= res_d;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !s_tready)
		else $error("input taken while a query scan is running");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_scan_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !out_vld_q)
		else $error("result slot occupied during a scan");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == drt_pkg::OP_CLEAR) |=> (cnt_q == '0 && !red_q))
		else $error("clear left entries or the redraw flag");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	localparam int TABLE_SLOTS    = 32;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_ITEMS   = 420;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid;
	logic         s_tready;
	logic [63:0]  s_tdata;   // rect_x, rect_y, rect_width, rect_height
	logic [2:0]   s_tuser;   // opcode
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [143:0] m_tdata;   // hit, full_redraw, region_count, frame_kind,
	                         // frame_total, full_total, partial_total, skipped_total

	// Shadow of the tracker state, updated as each input beat is accepted.
	drt_pkg::rect_t damage_table [TABLE_SLOTS];
	int          held_count;
	bit          redraw_flag;
	bit          track_on;
	logic [31:0] frames_ended;
	logic [31:0] full_ended;
	logic [31:0] partial_ended;
	logic [31:0] skipped_ended;

	drt_pkg::result_t pending_results [$];
	int      mismatch_count = 0;
	int      items_sent = 0;
	int      tx_max_gap = 13;
	int      rx_max_stall = 13;
	int      stall_left = 0;
	int      quiet_cycles = 0;

	always #10 clk = ~clk;

	dirty_rectangle_tracker #(
		.TABLE_DEPTH(TABLE_SLOTS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	function automatic drt_pkg::rect_t mk_rect(int x, int y, int w, int h);
		drt_pkg::rect_t r;
		r.x = 16'(x);
		r.y = 16'(y);
		r.w = 16'(w);
		r.h = 16'(h);
		return r;
	endfunction

	function automatic drt_pkg::rect_t random_rect();
		if ($urandom_range(0, 6) == 0)
			return drt_pkg::rect_t'({$urandom(), $urandom()});
		// Mostly a small window so that marks and queries overlap often.
		return mk_rect(int'($urandom_range(0, 80)) - 40, int'($urandom_range(0, 80)) - 40,
			int'($urandom_range(0, 28)) - 4, int'($urandom_range(0, 28)) - 4);
	endfunction

	// Strict half-open overlap; sums are taken at 32 bits so they cannot wrap.
	function automatic bit rects_overlap(drt_pkg::rect_t e, drt_pkg::rect_t q);
		int ex, ey, ew, eh, qx, qy, qw, qh;
		ex = $signed(e.x);
		ey = $signed(e.y);
		ew = $signed(e.w);
		eh = $signed(e.h);
		qx = $signed(q.x);
		qy = $signed(q.y);
		qw = $signed(q.w);
		qh = $signed(q.h);
		return (qx < ex + ew) && (qx + qw > ex) && (qy < ey + eh) && (qy + qh > ey);
	endfunction

	function automatic drt_pkg::result_t predict_damage(logic [2:0] op, drt_pkg::rect_t r);
		drt_pkg::result_t res;
		res = '0;
		res.frame_kind = drt_pkg::KIND_NONE;
		case (op)
			drt_pkg::OP_MARK: begin
				if (!track_on || held_count >= TABLE_SLOTS) begin
					redraw_flag = 1'b1;
				end else begin
					damage_table[held_count] = r;
					held_count++;
				end
			end
			drt_pkg::OP_MARK_ALL: begin
				redraw_flag = 1'b1;
				held_count = 0;
			end
			drt_pkg::OP_CLEAR: begin
				redraw_flag = 1'b0;
				held_count = 0;
			end
			drt_pkg::OP_QUERY: begin
				if (redraw_flag || !track_on) begin
					res.hit = 1'b1;
				end else begin
					for (int i = 0; i < held_count; i++)
						if (rects_overlap(damage_table[i], r))
							res.hit = 1'b1;
				end
			end
			drt_pkg::OP_END: begin
				frames_ended++;
				if (redraw_flag) begin
					full_ended++;
					res.frame_kind = drt_pkg::KIND_FULL;
				end else if (held_count > 0) begin
					partial_ended++;
					res.frame_kind = drt_pkg::KIND_PARTIAL;
				end else begin
					skipped_ended++;
					res.frame_kind = drt_pkg::KIND_SKIPPED;
				end
				redraw_flag = 1'b0;
				held_count = 0;
			end
			default: ;
		endcase
		res.full_redraw = redraw_flag;
		res.region_count = 6'(held_count);
		res.frame_total = frames_ended;
		res.full_total = full_ended;
		res.partial_total = partial_ended;
		res.skipped_total = skipped_ended;
		return res;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic send_item(logic [2:0] op, drt_pkg::rect_t r);
		int gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= r;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(predict_damage(op, r));
		items_sent++;
	endtask

	// Drops valid and waits until every result is back and the block has settled.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == drt_pkg::ADDR_TRACK_EN)
			track_on = data[0];
	endtask

	task automatic set_idle_profile();
		case ($urandom_range(0, 3))
			0: tx_max_gap = 0;
			1: tx_max_gap = 5;
			default: tx_max_gap = 13;
		endcase
		case ($urandom_range(0, 3))
			0: rx_max_stall = 0;
			1: rx_max_stall = 5;
			default: rx_max_stall = 13;
		endcase
	endtask

	// Full redraw is set out of reset, so the first query hits and the first frame is full.
	task automatic test_reset_state();
		send_item(drt_pkg::OP_QUERY, mk_rect(0, 0, 1, 1));
		send_item(drt_pkg::OP_MARK, mk_rect(1, 2, 3, 4));
		send_item(drt_pkg::OP_END, mk_rect(0, 0, 0, 0));
		send_item(drt_pkg::OP_END, mk_rect(0, 0, 0, 0));
		send_item(3'd5, mk_rect(-1, -1, -1, -1));
		send_item(3'd6, mk_rect(0, 0, 0, 0));
		send_item(3'd7, mk_rect(32767, -32768, 32767, -32768));
	endtask

	task automatic test_extremes();
		send_item(drt_pkg::OP_CLEAR, mk_rect(0, 0, 0, 0));
		send_item(drt_pkg::OP_MARK, mk_rect(-32768, -32768, 32767, 32767));
		send_item(drt_pkg::OP_MARK, mk_rect(32767, 32767, 32767, 32767));
		send_item(drt_pkg::OP_MARK, mk_rect(0, 0, 0, 5));
		send_item(drt_pkg::OP_MARK, mk_rect(100, 100, -10, -10));
		// Touching the right edge of a half-open range must miss.
		send_item(drt_pkg::OP_QUERY, mk_rect(-1, -1, 1, 1));
		send_item(drt_pkg::OP_QUERY, mk_rect(-2, -2, 1, 1));
		send_item(drt_pkg::OP_QUERY, mk_rect(32766, 32766, 2, 2));
		send_item(drt_pkg::OP_QUERY, mk_rect(0, 0, 0, 5));
		send_item(drt_pkg::OP_QUERY, mk_rect(95, 95, 3, 3));
		send_item(drt_pkg::OP_QUERY, mk_rect(-32768, -32768, -32768, -32768));
		send_item(drt_pkg::OP_QUERY, mk_rect(32767, -32768, 32767, -32768));
		send_item(drt_pkg::OP_END, mk_rect(0, 0, 0, 0));
		send_item(drt_pkg::OP_MARK_ALL, mk_rect(0, 0, 0, 0));
		send_item(drt_pkg::OP_QUERY, mk_rect(32767, 32767, 1, 1));
		send_item(drt_pkg::OP_END, mk_rect(0, 0, 0, 0));
		send_item(drt_pkg::OP_QUERY, mk_rect(0, 0, 100, 100));
		send_item(drt_pkg::OP_END, mk_rect(0, 0, 0, 0));
	endtask

	task automatic test_table_full();
		send_item(drt_pkg::OP_CLEAR, mk_rect(0, 0, 0, 0));
		for (int i = 0; i <= TABLE_SLOTS; i++)
			send_item(drt_pkg::OP_MARK, mk_rect(i * 4, i * 4, 2, 2));
		send_item(drt_pkg::OP_CLEAR, mk_rect(0, 0, 0, 0));
		for (int i = 0; i < TABLE_SLOTS; i++)
			send_item(drt_pkg::OP_MARK, mk_rect(i * 4, 0, 2, 2));
		// Only the last slot overlaps, so the search must run to the end.
		send_item(drt_pkg::OP_QUERY, mk_rect((TABLE_SLOTS - 1) * 4 + 1, 1, 1, 1));
		send_item(drt_pkg::OP_QUERY, mk_rect(-10, -10, 5, 5));
		send_item(drt_pkg::OP_END, mk_rect(0, 0, 0, 0));
	endtask

	task automatic test_tracking_off();
		wait_idle();
		write_reg(drt_pkg::ADDR_TRACK_EN, 32'hFFFF_FFFE);
		send_item(drt_pkg::OP_CLEAR, mk_rect(0, 0, 0, 0));
		send_item(drt_pkg::OP_MARK, mk_rect(5, 5, 5, 5));
		send_item(drt_pkg::OP_QUERY, mk_rect(-500, -500, 1, 1));
		send_item(drt_pkg::OP_END, mk_rect(0, 0, 0, 0));
		send_item(drt_pkg::OP_QUERY, mk_rect(-500, -500, 1, 1));
		send_item(drt_pkg::OP_END, mk_rect(0, 0, 0, 0));
		wait_idle();
		write_reg(drt_pkg::ADDR_TRACK_EN, 32'd1);
		send_item(drt_pkg::OP_CLEAR, mk_rect(0, 0, 0, 0));
		send_item(drt_pkg::OP_MARK, mk_rect(10, 10, 4, 4));
		wait_idle();
		// Stored entries survive while tracking is off; queries hit regardless.
		write_reg(drt_pkg::ADDR_TRACK_EN, 32'd0);
		send_item(drt_pkg::OP_QUERY, mk_rect(-500, -500, 1, 1));
		send_item(drt_pkg::OP_MARK, mk_rect(20, 20, 4, 4));
		wait_idle();
		write_reg(drt_pkg::ADDR_TRACK_EN, 32'd1);
		send_item(drt_pkg::OP_QUERY, mk_rect(11, 11, 1, 1));
		send_item(drt_pkg::OP_CLEAR, mk_rect(0, 0, 0, 0));
		send_item(drt_pkg::OP_QUERY, mk_rect(11, 11, 1, 1));
		send_item(drt_pkg::OP_END, mk_rect(0, 0, 0, 0));
	endtask

	task automatic run_random_frame();
		int opener, n_marks;
		opener = $urandom_range(0, 9);
		if (opener < 4)
			send_item(drt_pkg::OP_CLEAR, random_rect());
		else if (opener == 4)
			send_item(drt_pkg::OP_MARK_ALL, random_rect());
		n_marks = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
		for (int i = 0; i < n_marks; i++) begin
			send_item(drt_pkg::OP_MARK, random_rect());
			if ($urandom_range(0, 3) == 0)
				send_item(drt_pkg::OP_QUERY, random_rect());
		end
		repeat ($urandom_range(1, 4)) send_item(drt_pkg::OP_QUERY, random_rect());
		send_item(drt_pkg::OP_END, random_rect());
	endtask

	task automatic test_random_traffic();
		int target, next_phase;
		target = items_sent + RANDOM_ITEMS;
		next_phase = items_sent;
		while (items_sent < target) begin
			if (items_sent >= next_phase) begin
				wait_idle();
				write_reg(drt_pkg::ADDR_TRACK_EN,
					($urandom_range(0, 2) == 0) ? 32'd0 : 32'd1);
				set_idle_profile();
				next_phase = items_sent + 110;
			end
			if ($urandom_range(0, 9) == 0)
				send_item(3'($urandom_range(0, 7)),
					drt_pkg::rect_t'({$urandom(), $urandom()}));
			else
				run_random_frame();
		end
		tx_max_gap = 13;
		rx_max_stall = 13;
	endtask

	// Result sink: draws a stall before each beat.
	always @(posedge clk) begin : result_sink
		int wait_n;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else if (m_tvalid && m_tready) begin
			wait_n = $urandom_range(0, rx_max_stall);
			stall_left <= (wait_n > 0) ? wait_n - 1 : 0;
			m_tready <= (wait_n == 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		drt_pkg::result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				$error("result beat arrived with nothing expected");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("hit", want.hit, got.hit);
				check_field("full_redraw", want.full_redraw, got.full_redraw);
				check_field("region_count", want.region_count, got.region_count);
				check_field("frame_kind", want.frame_kind, got.frame_kind);
				check_field("frame_total", want.frame_total, got.frame_total);
				check_field("full_total", want.full_total, got.full_total);
				check_field("partial_total", want.partial_total, got.partial_total);
				check_field("skipped_total", want.skipped_total, got.skipped_total);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$error("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= drt_pkg::OP_CLEAR;
		held_count = 0;
		redraw_flag = 1'b1;
		track_on = 1'b1;
		frames_ended = '0;
		full_ended = '0;
		partial_ended = '0;
		skipped_ended = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_extremes();
		test_table_full();
		test_tracking_off();
		test_random_traffic();
		wait_idle();
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
sv/drt_pkg.sv
sv/drt_ram.sv
sv/drt_overlap.sv
sv/dirty_rectangle_tracker.sv
tb/testbench.sv
